>>> design/bec_pkg.sv
// ----------------------------------------------------------------------------
// bec_pkg - shared types and constants for the Bezier easing evaluator
// Controller command and status records, operand and accumulator codes,
// I/O field widths and the register map.
// ----------------------------------------------------------------------------
`default_nettype none

package bec_pkg;

    localparam int          IO_W        = 17;
    localparam logic [16:0] IO_ONE      = 17'd65536;
    localparam int          LIMIT_W     = 8;
    localparam logic [7:0]  LIMIT_RESET = 8'd12;
    localparam int          APB_ADDR_W  = 3;
    localparam int          APB_DATA_W  = 32;

    localparam logic [APB_ADDR_W-3:0] REG_ITER_LIMIT = '0;

    typedef enum logic [3:0] {
        OPD_T,
        OPD_PROD,
        OPD_T2,
        OPD_R,
        OPD_K0,
        OPD_K1,
        OPD_K2,
        OPD_Y1,
        OPD_Y2
    } opd_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_LOAD_SUBX,
        ACC_ADD,
        ACC_ADD3
    } acc_op_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        opd_sel_t a_sel;
        opd_sel_t b_sel;
        acc_op_t  acc_op;
        logic     t2_load;
        logic     r_load;
        logic     t_step;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic identity;
        logic in_tol;
    } status_t;

endpackage

`default_nettype wire

>>> design/bec_sample_if.sv
// ----------------------------------------------------------------------------
// bec_sample_if - input channel of the Bezier easing evaluator
// Time along the curve and the two inner control points.
// ----------------------------------------------------------------------------
`default_nettype none

interface bec_sample_if;
    logic        valid;
    logic        ready;
    logic [16:0] x_in;
    logic [16:0] ctrl_x1;
    logic [16:0] ctrl_y1;
    logic [16:0] ctrl_x2;
    logic [16:0] ctrl_y2;

    modport source (output valid, x_in, ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2, input ready);
    modport sink   (input valid, x_in, ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2, output ready);
endinterface

`default_nettype wire

>>> design/bec_result_if.sv
// ----------------------------------------------------------------------------
// bec_result_if - result channel of the Bezier easing evaluator
// Eased value, Q1.16.
// ----------------------------------------------------------------------------
`default_nettype none

interface bec_result_if;
    logic        valid;
    logic        ready;
    logic [16:0] y_out;

    modport source (output valid, y_out, input ready);
    modport sink   (input valid, y_out, output ready);
endinterface

`default_nettype wire

>>> design/bezier_easing_curve_eval_top.sv
// ----------------------------------------------------------------------------
// bezier_easing_curve_eval_top - cubic Bezier easing, time to eased value
// Solves x(t) = x for t by repeated half steps, then evaluates y(t).
//
//   channel  dir  handshake      payload
//   sample   in   valid/ready    x_in, ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2
//   result   out  valid/ready    y_out
//   apb      in   psel/penable   paddr, pwdata, prdata (iteration_limit at 0x0)
//
// The number of f(t) evaluations is at most iteration_limit; an identity
// curve skips them.
// All multiplies share one rounding multiplier, one per cycle.
// One transaction in flight; a new one is taken while the result waits.
// A stalled result holds the sequencer in its last state.
// Asynchronous active-low reset; iteration_limit resets to 12.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_easing_curve_eval_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    bec_sample_if.sink                             sample,
    bec_result_if.source                           result,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bec_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [bec_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [bec_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);

    logic [bec_pkg::LIMIT_W-1:0] iter_limit_reg;
    logic                        reg_hit;
    bec_pkg::cmd_t               cmd;
    bec_pkg::status_t            status;

    assign reg_hit = (paddr[bec_pkg::APB_ADDR_W-1:2] == bec_pkg::REG_ITER_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_limit_reg <= bec_pkg::LIMIT_RESET;
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            iter_limit_reg <= pwdata[bec_pkg::LIMIT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_hit ? bec_pkg::APB_DATA_W'(iter_limit_reg) : '0;

    bec_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample.valid),
        .in_ready   (sample.ready),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .iter_limit (iter_limit_reg),
        .status     (status),
        .cmd        (cmd)
    );

    bec_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk     (clk),
        .cmd     (cmd),
        .x_in    (sample.x_in),
        .ctrl_x1 (sample.ctrl_x1),
        .ctrl_y1 (sample.ctrl_y1),
        .ctrl_x2 (sample.ctrl_x2),
        .ctrl_y2 (sample.ctrl_y2),
        .status  (status),
        .y_out   (result.y_out)
    );

endmodule

`default_nettype wire

>>> design/bec_datapath.sv
// ----------------------------------------------------------------------------
// bec_datapath - operand registers, shared multiplier and accumulator
// One rounded fixed-point multiply per cycle into the product register,
// accumulation of polynomial terms, half-residual step of t and output
// conversion back to Q1.16.
// ----------------------------------------------------------------------------
`default_nettype none

module bec_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic           clk,
    input  wire bec_pkg::cmd_t  cmd,
    input  wire logic [16:0]    x_in,
    input  wire logic [16:0]    ctrl_x1,
    input  wire logic [16:0]    ctrl_y1,
    input  wire logic [16:0]    ctrl_x2,
    input  wire logic [16:0]    ctrl_y2,
    output bec_pkg::status_t    status,
    output logic [16:0]         y_out
);

    localparam int W   = FRAC_BITS + 15;
    localparam int MW  = FRAC_BITS + 10;
    localparam int PW  = 2 * MW;
    localparam int UP  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int DN  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int EPS = (2**FRAC_BITS * 5 + 5000) / 10000;

    localparam logic signed [W-1:0] ONE_Q   = W'(1) << FRAC_BITS;
    localparam logic signed [W-1:0] EPS_Q   = W'(EPS);
    localparam logic signed [W-1:0] T_LIM   = ONE_Q <<< 3;
    localparam logic [PW-1:0]       HALF_P  = PW'(1) << (FRAC_BITS - 1);
    localparam logic [W-1:0]        HALF_UP = (W'(1) << UP) >> 1;
    localparam logic [W-1:0]        IO_ONE_W = W'(bec_pkg::IO_ONE);

    logic signed [W-1:0] x_reg, k0_reg, k1_reg, k2_reg, y1_reg, y2_reg;
    logic signed [W-1:0] t_reg, t2_reg, r_reg, prod_reg, acc_reg;
    logic [16:0]         x_raw_reg;
    logic                id_reg;
    logic [16:0]         y_out_reg;

    logic signed [W-1:0] xi, x1i, y1i, x2i, y2i;
    logic signed [W-1:0] opd_a, opd_b, mag_a, mag_b, mul_res;
    logic [PW-1:0]       prod_mag, prod_rnd;
    logic [W-1:0]        rnd_w;
    logic                neg;
    logic signed [W-1:0] prod3, f_mag, f_half, t_sum, t_next;
    logic signed [W-1:0] y_sat;
    logic [W-1:0]        y_conv;
    logic [16:0]         y_final, y_ident;

    assign xi  = signed'((W'(x_in) << UP) >> DN);
    assign x1i = signed'((W'(ctrl_x1) << UP) >> DN);
    assign y1i = signed'((W'(ctrl_y1) << UP) >> DN);
    assign x2i = signed'((W'(ctrl_x2) << UP) >> DN);
    assign y2i = signed'((W'(ctrl_y2) << UP) >> DN);

    always_comb
    begin
        case (cmd.a_sel)
            bec_pkg::OPD_T:    opd_a = t_reg;
            bec_pkg::OPD_PROD: opd_a = prod_reg;
            bec_pkg::OPD_T2:   opd_a = t2_reg;
            bec_pkg::OPD_R:    opd_a = r_reg;
            bec_pkg::OPD_K0:   opd_a = k0_reg;
            bec_pkg::OPD_K1:   opd_a = k1_reg;
            bec_pkg::OPD_K2:   opd_a = k2_reg;
            bec_pkg::OPD_Y1:   opd_a = y1_reg;
            bec_pkg::OPD_Y2:   opd_a = y2_reg;
            default:           opd_a = t_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.b_sel)
            bec_pkg::OPD_T:    opd_b = t_reg;
            bec_pkg::OPD_PROD: opd_b = prod_reg;
            bec_pkg::OPD_T2:   opd_b = t2_reg;
            bec_pkg::OPD_R:    opd_b = r_reg;
            bec_pkg::OPD_K0:   opd_b = k0_reg;
            bec_pkg::OPD_K1:   opd_b = k1_reg;
            bec_pkg::OPD_K2:   opd_b = k2_reg;
            bec_pkg::OPD_Y1:   opd_b = y1_reg;
            bec_pkg::OPD_Y2:   opd_b = y2_reg;
            default:           opd_b = t_reg;
        endcase
    end

    // sign-magnitude multiply, round half away from zero
    assign neg      = opd_a[W-1] ^ opd_b[W-1];
    assign mag_a    = opd_a[W-1] ? -opd_a : opd_a;
    assign mag_b    = opd_b[W-1] ? -opd_b : opd_b;
    assign prod_mag = PW'(mag_a[MW-1:0]) * PW'(mag_b[MW-1:0]);
    assign prod_rnd = (prod_mag + HALF_P) >> FRAC_BITS;
    assign rnd_w    = prod_rnd[W-1:0];
    assign mul_res  = neg ? -signed'(rnd_w) : signed'(rnd_w);

    assign prod3 = (prod_reg <<< 1) + prod_reg;

    // step t against the sign of f, then hold within the guard range
    assign f_mag  = acc_reg[W-1] ? -acc_reg : acc_reg;
    assign f_half = signed'(W'(f_mag) >> 1);
    assign t_sum  = acc_reg[W-1] ? t_reg + f_half : t_reg - f_half;
    assign t_next = (t_sum > T_LIM) ? T_LIM : ((t_sum < -T_LIM) ? -T_LIM : t_sum);

    assign y_sat   = (acc_reg < 0) ? '0 : ((acc_reg > ONE_Q) ? ONE_Q : acc_reg);
    assign y_conv  = ((W'(y_sat) + HALF_UP) >> UP) << DN;
    assign y_final = (y_conv > IO_ONE_W) ? bec_pkg::IO_ONE : y_conv[16:0];
    assign y_ident = (x_raw_reg > bec_pkg::IO_ONE) ? bec_pkg::IO_ONE : x_raw_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_raw_reg <= x_in;
            id_reg    <= (ctrl_x1 == ctrl_y1) && (ctrl_x2 == ctrl_y2);
            x_reg     <= xi;
            y1_reg    <= y1i;
            y2_reg    <= y2i;
            k0_reg    <= ONE_Q + (x1i <<< 1) + x1i - (x2i <<< 1) - x2i;
            k1_reg    <= (x2i <<< 1) + x2i - (x1i <<< 2) - (x1i <<< 1);
            k2_reg    <= (x1i <<< 1) + x1i;
            t_reg     <= xi;
        end
        else if (cmd.t_step)
        begin
            t_reg <= t_next;
        end

        if (cmd.mul_en)
        begin
            prod_reg <= mul_res;
        end

        if (cmd.t2_load)
        begin
            t2_reg <= prod_reg;
        end

        if (cmd.r_load)
        begin
            r_reg <= ONE_Q - t_reg;
        end

        case (cmd.acc_op)
            bec_pkg::ACC_HOLD:      acc_reg <= acc_reg;
            bec_pkg::ACC_LOAD:      acc_reg <= prod_reg;
            bec_pkg::ACC_LOAD_SUBX: acc_reg <= prod_reg - x_reg;
            bec_pkg::ACC_ADD:       acc_reg <= acc_reg + prod_reg;
            bec_pkg::ACC_ADD3:      acc_reg <= acc_reg + prod3;
            default:                acc_reg <= acc_reg;
        endcase

        if (cmd.out_load)
        begin
            y_out_reg <= id_reg ? y_ident : y_final;
        end
    end

    assign status.identity = id_reg;
    assign status.in_tol   = (acc_reg <= EPS_Q) && (acc_reg >= -EPS_Q);
    assign y_out           = y_out_reg;

endmodule

`default_nettype wire

>>> design/bec_controller.sv
// ----------------------------------------------------------------------------
// bec_controller - sequencer for the Bezier easing evaluator
// Issues one datapath command per cycle: refinement passes of t, the final
// cubic for y, and the hand-off to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bec_controller (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire logic [7:0]        iter_limit,
    input  wire bec_pkg::status_t  status,
    output bec_pkg::cmd_t          cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_TT,
        ST_T3,
        ST_IA,
        ST_IB,
        ST_IC,
        ST_IF,
        ST_CHK,
        ST_FP,
        ST_FQ,
        ST_FRR,
        ST_FS,
        ST_FU,
        ST_FACC,
        ST_DONE
    } state_t;

    state_t     state_reg;
    logic [7:0] cnt_reg;
    logic       fin_reg;
    logic       out_valid_reg;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_DONE) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    cnt_reg   <= '0;
                    fin_reg   <= 1'b0;
                    state_reg <= status.identity ? ST_DONE : ST_TT;
                end
                ST_TT:   state_reg <= ST_T3;
                ST_T3:   state_reg <= (fin_reg || (cnt_reg == iter_limit)) ? ST_FP : ST_IA;
                ST_IA:   state_reg <= ST_IB;
                ST_IB:   state_reg <= ST_IC;
                ST_IC:   state_reg <= ST_IF;
                ST_IF:   state_reg <= ST_CHK;
                ST_CHK:
                begin
                    if (status.in_tol)
                    begin
                        fin_reg <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 8'd1;
                    end
                    state_reg <= ST_TT;
                end
                ST_FP:   state_reg <= ST_FQ;
                ST_FQ:   state_reg <= ST_FRR;
                ST_FRR:  state_reg <= ST_FS;
                ST_FS:   state_reg <= ST_FU;
                ST_FU:   state_reg <= ST_FACC;
                ST_FACC: state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (slot_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.a_sel    = bec_pkg::OPD_T;
        cmd.b_sel    = bec_pkg::OPD_T;
        cmd.acc_op   = bec_pkg::ACC_HOLD;
        case (state_reg)
            ST_IDLE: cmd.load = in_valid;
            ST_TT:
            begin
                cmd.mul_en = 1'b1;
            end
            ST_T3:
            begin
                cmd.mul_en  = 1'b1;
                cmd.a_sel   = bec_pkg::OPD_PROD;
                cmd.t2_load = 1'b1;
                cmd.r_load  = 1'b1;
            end
            ST_IA:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel  = bec_pkg::OPD_K0;
                cmd.b_sel  = bec_pkg::OPD_PROD;
            end
            ST_IB:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel  = bec_pkg::OPD_K1;
                cmd.b_sel  = bec_pkg::OPD_T2;
                cmd.acc_op = bec_pkg::ACC_LOAD_SUBX;
            end
            ST_IC:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel  = bec_pkg::OPD_K2;
                cmd.acc_op = bec_pkg::ACC_ADD;
            end
            ST_IF:   cmd.acc_op = bec_pkg::ACC_ADD;
            ST_CHK:  cmd.t_step = !status.in_tol;
            ST_FP:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel  = bec_pkg::OPD_T2;
                cmd.b_sel  = bec_pkg::OPD_R;
                cmd.acc_op = bec_pkg::ACC_LOAD;
            end
            ST_FQ:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel  = bec_pkg::OPD_PROD;
                cmd.b_sel  = bec_pkg::OPD_Y2;
            end
            ST_FRR:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel  = bec_pkg::OPD_R;
                cmd.b_sel  = bec_pkg::OPD_R;
                cmd.acc_op = bec_pkg::ACC_ADD3;
            end
            ST_FS:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel  = bec_pkg::OPD_PROD;
            end
            ST_FU:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel  = bec_pkg::OPD_PROD;
                cmd.b_sel  = bec_pkg::OPD_Y1;
            end
            ST_FACC: cmd.acc_op   = bec_pkg::ACC_ADD3;
            ST_DONE: cmd.out_load = slot_free;
            default: cmd.load     = 1'b0;
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> design/bec_checker.sv
// ----------------------------------------------------------------------------
// bec_checker - port-level checks for the Bezier easing evaluator
// Result range, one transaction at a time, register read-back and result
// channel stability.
// ----------------------------------------------------------------------------
`default_nettype none

module bec_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [16:0] y_out,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(y_out))
        else $error("result changed while stalled");

    a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (y_out <= 17'd65536))
        else $error("result above one");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while busy");

    a_reg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[2] == 1'b0)) ##1 (paddr[2] == 1'b0)
        |-> (prdata == {24'd0, $past(pwdata[7:0])}))
        else $error("iteration limit read-back mismatch");

endmodule

bind bezier_easing_curve_eval_top bec_checker u_bec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .y_out     (result.y_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

`default_nettype wire

>>> dv/tb_bezier_easing_curve_eval_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bezier_easing_curve_eval_top - self-checking bench for the easing solver
// Streams time and control-point samples through the evaluator under random
// valid/ready idling, predicts each eased value with a bit-exact fixed-point
// solver of its own and compares every result in order. The iteration limit
// is reprogrammed over APB between batches, including zero, one and 255,
// and read back.
// ----------------------------------------------------------------------------

module tb_bezier_easing_curve_eval_top;

    localparam int FRAC           = 16;
    localparam longint ONE_Q      = longint'(1) << FRAC;
    localparam longint TOL_Q      = (ONE_Q * 5 + 5000) / 10000;
    localparam longint T_BOUND    = ONE_Q * 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 200;

    localparam logic [bec_pkg::APB_ADDR_W-3:0] REG_UNMAPPED = 1'b1;

    typedef struct packed {
        logic [16:0] x_in;
        logic [16:0] ctrl_x1;
        logic [16:0] ctrl_y1;
        logic [16:0] ctrl_x2;
        logic [16:0] ctrl_y2;
    } bezier_sample_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [bec_pkg::APB_ADDR_W-1:0] paddr;
    logic [bec_pkg::APB_DATA_W-1:0] pwdata;
    logic [bec_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    bec_sample_if sample_ch ();
    bec_result_if result_ch ();

    bezier_easing_curve_eval_top #(
        .FRAC_BITS (FRAC)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bezier_sample_t pending_samples[$];
    logic [16:0]    expected_y[$];
    logic [7:0]     iter_limit_model;
    bezier_sample_t next_sample;
    bezier_sample_t seen_sample;
    logic [16:0]    want_y;
    logic           stall_enable;
    int             send_gap;
    int             recv_gap;
    int             mismatch_count;
    int             idle_cycles;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint mul_round(input longint a, input longint b);
        longint unsigned mag_a;
        longint unsigned mag_b;
        longint unsigned prod;
        mag_a = (a < 0) ? longint'(-a) : a;
        mag_b = (b < 0) ? longint'(-b) : b;
        prod  = (mag_a * mag_b + (64'd1 << (FRAC - 1))) >> FRAC;
        return ((a < 0) != (b < 0)) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic logic [16:0] eased_value(input bezier_sample_t s,
                                                input logic [7:0] limit);
        longint x, x1, y1, x2, y2;
        longint k0, k1, k2;
        longint t, t2, t3, f, half, r, y;
        bit     settled;
        int     i;
        if (s.ctrl_x1 == s.ctrl_y1 && s.ctrl_x2 == s.ctrl_y2)
            return (s.x_in > bec_pkg::IO_ONE) ? bec_pkg::IO_ONE : s.x_in;
        x  = longint'(s.x_in);
        x1 = longint'(s.ctrl_x1);
        y1 = longint'(s.ctrl_y1);
        x2 = longint'(s.ctrl_x2);
        y2 = longint'(s.ctrl_y2);
        k0 = ONE_Q + 3 * x1 - 3 * x2;
        k1 = 3 * x2 - 6 * x1;
        k2 = 3 * x1;
        t  = x;
        settled = 1'b0;
        for (i = 0; i < int'(limit) && !settled; i++)
        begin
            t2 = mul_round(t, t);
            t3 = mul_round(t2, t);
            f  = mul_round(k0, t3) + mul_round(k1, t2) + mul_round(k2, t) - x;
            if (f <= TOL_Q && f >= -TOL_Q)
                settled = 1'b1;
            else
            begin
                half = ((f < 0) ? -f : f) >>> 1;
                t = (f < 0) ? t + half : t - half;
                if (t > T_BOUND)
                    t = T_BOUND;
                else if (t < -T_BOUND)
                    t = -T_BOUND;
            end
        end
        r  = ONE_Q - t;
        t2 = mul_round(t, t);
        y  = mul_round(t2, t)
           + 3 * mul_round(mul_round(t2, r), y2)
           + 3 * mul_round(mul_round(t, mul_round(r, r)), y1);
        if (y < 0)
            y = 0;
        else if (y > ONE_Q)
            y = ONE_Q;
        return y[16:0];
    endfunction

    function automatic logic [16:0] pick_field(input int unsigned hi);
        case ($urandom_range(0, 15))
            0:       return 17'd0;
            1:       return (hi >= 65536) ? bec_pkg::IO_ONE : 17'(hi);
            2:       return 17'(hi);
            default: return 17'($urandom_range(0, hi));
        endcase
    endfunction

    function automatic bezier_sample_t random_sample();
        bezier_sample_t s;
        int unsigned    pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            s.x_in    = pick_field(65536);
            s.ctrl_x1 = pick_field(65536);
            s.ctrl_y1 = pick_field(98304);
            s.ctrl_x2 = pick_field(65536);
            s.ctrl_y2 = pick_field(98304);
        end
        else if (pick == 7)
        begin
            s.x_in    = pick_field(131071);
            s.ctrl_x1 = pick_field(131071);
            s.ctrl_y1 = s.ctrl_x1;
            s.ctrl_x2 = pick_field(131071);
            s.ctrl_y2 = s.ctrl_x2;
        end
        else
        begin
            s.x_in    = pick_field(131071);
            s.ctrl_x1 = pick_field(131071);
            s.ctrl_y1 = pick_field(131071);
            s.ctrl_x2 = pick_field(131071);
            s.ctrl_y2 = pick_field(131071);
        end
        return s;
    endfunction

    task automatic note_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch in %s: expected %0d, got %0d", what, want, got);
    endtask

    task automatic add_sample(input logic [16:0] x, input logic [16:0] x1,
                              input logic [16:0] y1, input logic [16:0] x2,
                              input logic [16:0] y2);
        pending_samples.push_back('{x_in: x, ctrl_x1: x1, ctrl_y1: y1,
                                    ctrl_x2: x2, ctrl_y2: y2});
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || sample_ch.valid || expected_y.size() != 0);
    endtask

    task automatic run_random(input int count);
        @(negedge clk);
        repeat (count)
            pending_samples.push_back(random_sample());
        wait_drained();
    endtask

    task automatic apb_write(input logic [bec_pkg::APB_ADDR_W-3:0] index,
                             input logic [bec_pkg::APB_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == bec_pkg::REG_ITER_LIMIT)
            iter_limit_model = value[7:0];
    endtask

    task automatic check_limit_reg();
        logic [bec_pkg::APB_DATA_W-1:0] got;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {bec_pkg::REG_ITER_LIMIT, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== bec_pkg::APB_DATA_W'(iter_limit_model))
            note_mismatch("iteration_limit readback", iter_limit_model, got);
    endtask

    task automatic set_limit(input logic [7:0] value);
        apb_write(bec_pkg::REG_ITER_LIMIT, bec_pkg::APB_DATA_W'(value));
        check_limit_reg();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            send_gap        <= 0;
        end
        else if (!sample_ch.valid || sample_ch.ready)
        begin
            if (send_gap != 0)
            begin
                send_gap        <= send_gap - 1;
                sample_ch.valid <= 1'b0;
            end
            else if (stall_enable && pending_samples.size() != 0
                     && $urandom_range(0, 5) == 0)
            begin
                send_gap        <= $urandom_range(0, 2);
                sample_ch.valid <= 1'b0;
            end
            else if (pending_samples.size() != 0)
            begin
                next_sample       = pending_samples.pop_front();
                sample_ch.x_in    <= next_sample.x_in;
                sample_ch.ctrl_x1 <= next_sample.ctrl_x1;
                sample_ch.ctrl_y1 <= next_sample.ctrl_y1;
                sample_ch.ctrl_x2 <= next_sample.ctrl_x2;
                sample_ch.ctrl_y2 <= next_sample.ctrl_y2;
                sample_ch.valid   <= 1'b1;
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            recv_gap        <= 0;
        end
        else if (recv_gap != 0)
        begin
            result_ch.ready <= 1'b0;
            recv_gap        <= recv_gap - 1;
        end
        else if (stall_enable && $urandom_range(0, 5) == 0)
        begin
            result_ch.ready <= 1'b0;
            recv_gap        <= $urandom_range(0, 2);
        end
        else
            result_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                seen_sample = '{x_in: sample_ch.x_in, ctrl_x1: sample_ch.ctrl_x1,
                                ctrl_y1: sample_ch.ctrl_y1, ctrl_x2: sample_ch.ctrl_x2,
                                ctrl_y2: sample_ch.ctrl_y2};
                expected_y.push_back(eased_value(seen_sample, iter_limit_model));
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_y.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result y_out=%0d", result_ch.y_out);
                end
                else
                begin
                    want_y = expected_y.pop_front();
                    if (result_ch.y_out !== want_y)
                        note_mismatch("y_out", want_y, result_ch.y_out);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || (psel && penable && pready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        sample_ch.valid   = 1'b0;
        sample_ch.x_in    = '0;
        sample_ch.ctrl_x1 = '0;
        sample_ch.ctrl_y1 = '0;
        sample_ch.ctrl_x2 = '0;
        sample_ch.ctrl_y2 = '0;
        result_ch.ready   = 1'b0;
        stall_enable      = 1'b1;
        mismatch_count    = 0;
        idle_cycles       = 0;
        iter_limit_model  = bec_pkg::LIMIT_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        check_limit_reg();

        @(negedge clk);
        add_sample(17'd0,      17'd0,      17'd0,      17'd0,      17'd0);
        add_sample(17'd65536,  17'd16384,  17'd16384,  17'd49152,  17'd49152);
        add_sample(17'd131071, 17'd131071, 17'd131071, 17'd0,      17'd0);
        add_sample(17'd0,      17'd16384,  17'd6554,   17'd16384,  17'd65536);
        add_sample(17'd32768,  17'd16384,  17'd6554,   17'd16384,  17'd65536);
        add_sample(17'd65536,  17'd16384,  17'd6554,   17'd16384,  17'd65536);
        add_sample(17'd16384,  17'd27525,  17'd0,      17'd38011,  17'd65536);
        add_sample(17'd40000,  17'd20000,  17'd20000,  17'd30000,  17'd60000);
        add_sample(17'd50000,  17'd10000,  17'd50000,  17'd45000,  17'd45000);
        add_sample(17'd131071, 17'd0,      17'd65536,  17'd65536,  17'd0);
        add_sample(17'd65536,  17'd131071, 17'd0,      17'd131071, 17'd131071);
        add_sample(17'd0,      17'd0,      17'd131071, 17'd0,      17'd131071);
        add_sample(17'd1,      17'd65536,  17'd0,      17'd0,      17'd65536);
        add_sample(17'd131071, 17'd131071, 17'd131071, 17'd131071, 17'd0);
        add_sample(17'd98304,  17'd65536,  17'd65536,  17'd65536,  17'd0);
        add_sample(17'd32768,  17'd0,      17'd0,      17'd65536,  17'd65535);
        add_sample(17'h15555,  17'h0AAAA,  17'h15555,  17'h0AAAA,  17'h15555);
        add_sample(17'h0AAAA,  17'h15555,  17'h0AAAA,  17'h15555,  17'h0AAAA);
        wait_drained();

        set_limit(8'd0);
        @(negedge clk);
        add_sample(17'd16384,  17'd27525,  17'd0,      17'd38011,  17'd65536);
        add_sample(17'd131071, 17'd0,      17'd65536,  17'd65536,  17'd0);
        add_sample(17'd100,    17'd5000,   17'd5000,   17'd7000,   17'd7000);
        wait_drained();
        run_random(60);

        set_limit(8'd255);
        run_random(60);
        apb_write(REG_UNMAPPED, 32'd3);
        check_limit_reg();
        run_random(40);

        set_limit(8'd1);
        run_random(60);

        repeat (3)
        begin
            set_limit(8'($urandom_range(2, 40)));
            run_random(60);
        end

        set_limit(bec_pkg::LIMIT_RESET);
        run_random(170);

        stall_enable = 1'b0;
        run_random(60);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_y.size() != 0)
        begin
            mismatch_count += expected_y.size();
            $display("%0d results never arrived", expected_y.size());
        end
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
